// ===== rtl/core/dltq_pkg.sv =====
// Shared types and codes for the delta list timer queue.
package dltq_pkg;

	localparam int unsigned ID_W    = 4;
	localparam int unsigned TICKS_W = 32;

	// Request actions.
	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_DEL  = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;
	localparam logic [1:0] ACT_SVC  = 2'd3;

	// Modes of the command word that travels down the cell chain.
	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_ADD   = 3'd1;
	localparam logic [2:0] MODE_SHIFT = 3'd2;
	localparam logic [2:0] MODE_DEL   = 3'd3;
	localparam logic [2:0] MODE_PULL  = 3'd4;
	localparam logic [2:0] MODE_SUB   = 3'd5;

	typedef struct packed {
		logic [1:0]         action;
		logic [ID_W-1:0]    timer_id;
		logic [TICKS_W-1:0] timeout_ticks;
	} req_t;

	typedef struct packed {
		logic               expired;
		logic [ID_W-1:0]    expired_id;
		logic               status;
		logic               queue_empty;
		logic [TICKS_W-1:0] pending_ticks;
	} rsp_t;

	// One position of the sorted list.
	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [TICKS_W-1:0] delta;
	} entry_t;

	// Command word; left holds the remainder, the fold amount or the tick count.
	typedef struct packed {
		logic               live;
		logic [2:0]         mode;
		logic [ID_W-1:0]    id;
		logic [TICKS_W-1:0] left;
		entry_t             carry;
	} word_t;

endpackage

// ===== rtl/core/delta_list_timer_queue_core.sv =====
// Top level of the delta list timer queue: request control and the cell chain.
//
//  channel | signals                    | direction | payload
//  req     | req_valid, req_ready, req  | in        | action, timer_id, timeout_ticks
//  rsp     | rsp_valid, rsp_ready, rsp  | out       | expired, expired_id, status,
//          |                            |           | queue_empty, pending_ticks
//
// Tick, refused or empty requests are answered without a walk. An add, a delete,
// or a service that touches the head sends a command word down the chain of
// MAX_TIMERS cells, one cell per cycle, and is answered once the word has left
// the last cell. Reset empties the list at once.
// A response waits in its own register while rsp_ready is low, and a new request
// is taken only when that register is free or being emptied.
module delta_list_timer_queue_core #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dltq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dltq_pkg::rsp_t rsp
);
	import dltq_pkg::*;

	// Only ids that fit both the field and the chain can ever be queued.
	localparam int unsigned QW = (MAX_TIMERS < (1 << ID_W)) ? MAX_TIMERS : (1 << ID_W);
	localparam int unsigned IW = $clog2(QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]         state_q;
	word_t              inj_q;
	logic [TICKS_W-1:0] backlog_q;
	logic               exp_q;
	logic [ID_W-1:0]    exp_id_q;
	logic [QW-1:0]      queued_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	word_t  words [MAX_TIMERS+1];
	entry_t ents  [MAX_TIMERS];
	logic [MAX_TIMERS-1:0] cell_valid;

	assign words[0] = inj_q;

	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		entry_t nxt;
		if (i == MAX_TIMERS - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ents[i+1];
		end
		dltq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (words[i]),
			.next_ent (nxt),
			.ent      (ents[i]),
			.word_out (words[i+1])
		);
		assign cell_valid[i] = ents[i].valid;
	end

	entry_t             head;
	logic               chain_done;
	logic               rsp_free;
	logic               accept;
	logic               rsp_load;
	logic               id_ok;
	logic [IW-1:0]      idx;
	logic [IW-1:0]      hidx;
	logic               walk_d;
	word_t              inj_d;
	logic [TICKS_W-1:0] backlog_d;
	logic               status_d;
	logic               set_d;
	logic               clr_d;
	logic [IW-1:0]      clr_idx;
	logic               exp_d;
	logic [ID_W-1:0]    exp_id_d;

	assign head       = ents[0];
	assign chain_done = words[MAX_TIMERS].live;
	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE) && rsp_free;
	assign accept     = req_valid && req_ready;
	assign id_ok      = int'(req.timer_id) < MAX_TIMERS;
	assign idx        = req.timer_id[IW-1:0];
	assign hidx       = head.id[IW-1:0];

	// A response is loaded straight after a short request or at the end of a walk.
	assign rsp_load = (state_q == ST_IDLE) ? (accept && !walk_d)
	                                       : ((state_q == ST_FIN) && rsp_free);

	always_comb begin
		walk_d    = 1'b0;
		inj_d     = '0;
		backlog_d = backlog_q;
		status_d  = 1'b0;
		set_d     = 1'b0;
		clr_d     = 1'b0;
		clr_idx   = idx;
		exp_d     = 1'b0;
		exp_id_d  = '0;
		unique case (req.action)
			ACT_ADD: begin
				if (id_ok && queued_q[idx]) begin
					status_d = 1'b1;
				end else if (id_ok) begin
					walk_d     = 1'b1;
					inj_d.live = 1'b1;
					inj_d.mode = MODE_ADD;
					inj_d.id   = req.timer_id;
					inj_d.left = req.timeout_ticks;
					set_d      = 1'b1;
				end
			end
			ACT_DEL: begin
				if (id_ok && queued_q[idx]) begin
					walk_d     = 1'b1;
					inj_d.live = 1'b1;
					inj_d.mode = MODE_DEL;
					inj_d.id   = req.timer_id;
					clr_d      = 1'b1;
				end
			end
			ACT_TICK: begin
				if (backlog_q != '1) begin
					backlog_d = backlog_q + 1'b1;
				end
			end
			ACT_SVC: begin
				priority if (!head.valid) begin
					backlog_d = '0;
				end else if (backlog_q == '0) begin
					backlog_d = backlog_q;
				end else if (backlog_q < head.delta) begin
					walk_d     = 1'b1;
					inj_d.live = 1'b1;
					inj_d.mode = MODE_SUB;
					inj_d.left = backlog_q;
					backlog_d  = '0;
				end else begin
					// The head expires; the chain closes up behind it.
					walk_d     = 1'b1;
					inj_d.live = 1'b1;
					inj_d.mode = MODE_PULL;
					backlog_d  = backlog_q - head.delta;
					clr_d      = 1'b1;
					clr_idx    = hidx;
					exp_d      = 1'b1;
					exp_id_d   = head.id;
				end
			end
			default: begin
				walk_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inj_q       <= '0;
			backlog_q   <= '0;
			exp_q       <= 1'b0;
			exp_id_q    <= '0;
			queued_q    <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			inj_q <= (accept && walk_d) ? inj_d : '0;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						backlog_q <= backlog_d;
						if (set_d) begin
							queued_q[idx] <= 1'b1;
						end
						if (clr_d) begin
							queued_q[clr_idx] <= 1'b0;
						end
						if (walk_d) begin
							state_q  <= ST_WALK;
							exp_q    <= exp_d;
							exp_id_q <= exp_id_d;
						end else begin
							rsp_q.expired       <= 1'b0;
							rsp_q.expired_id    <= '0;
							rsp_q.status        <= status_d;
							rsp_q.queue_empty   <= !head.valid;
							rsp_q.pending_ticks <= backlog_d;
						end
					end
				end
				ST_WALK: begin
					if (chain_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						rsp_q.expired       <= exp_q;
						rsp_q.expired_id    <= exp_id_q;
						rsp_q.status        <= 1'b0;
						rsp_q.queue_empty   <= !head.valid;
						rsp_q.pending_ticks <= backlog_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A command word enters the chain only while a walk is under way.
	a_inj_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		inj_q.live |-> state_q == ST_WALK)
		else $error("command word injected outside a walk");

	// No request is taken before the chain has settled.
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req_ready)
		else $error("request taken while the chain is busy");

	// Between requests the occupied cells form an unbroken run from the head.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (cell_valid & (cell_valid + 1'b1)) == '0)
		else $error("gap in the timer chain");

	// The queued flags agree with the occupied cells between requests.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(queued_q) == $countones(cell_valid))
		else $error("queued flags disagree with the chain");

endmodule

// ===== rtl/core/dltq_cell.sv =====
// One list position of the timer queue chain, with its stage of the command word.
module dltq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  dltq_pkg::word_t  word_in,
	input  dltq_pkg::entry_t next_ent,
	output dltq_pkg::entry_t ent,
	output dltq_pkg::word_t  word_out
);
	import dltq_pkg::*;

	entry_t ent_q;
	entry_t ent_d;
	word_t  word_q;
	word_t  word_d;

	always_comb begin
		ent_d  = ent_q;
		word_d = word_in;
		if (word_in.live) begin
			unique case (word_in.mode)
				MODE_ADD: begin
					if (!ent_q.valid || ent_q.delta >= word_in.left) begin
						// Insert here; the displaced entry is pushed down the chain.
						ent_d.valid        = 1'b1;
						ent_d.id           = word_in.id;
						ent_d.delta        = word_in.left;
						word_d.mode        = MODE_SHIFT;
						word_d.carry.valid = ent_q.valid;
						word_d.carry.id    = ent_q.id;
						word_d.carry.delta = ent_q.delta - word_in.left;
					end else begin
						word_d.left = word_in.left - ent_q.delta;
					end
				end
				MODE_SHIFT: begin
					ent_d        = word_in.carry;
					word_d.carry = ent_q;
				end
				MODE_DEL: begin
					if (ent_q.valid && ent_q.id == word_in.id) begin
						// Take the successor and fold the removed delta into it.
						ent_d.valid = next_ent.valid;
						ent_d.id    = next_ent.id;
						ent_d.delta = next_ent.delta + ent_q.delta;
						word_d.mode = MODE_PULL;
						word_d.left = '0;
					end
				end
				MODE_PULL: begin
					ent_d.valid = next_ent.valid;
					ent_d.id    = next_ent.id;
					ent_d.delta = next_ent.delta + word_in.left;
					word_d.left = '0;
				end
				MODE_SUB: begin
					ent_d.delta = ent_q.delta - word_in.left;
					word_d.mode = MODE_IDLE;
				end
				default: begin
					ent_d = ent_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q  <= '0;
			word_q <= '0;
		end else begin
			ent_q  <= ent_d;
			word_q <= word_d;
		end
	end

	assign ent      = ent_q;
	assign word_out = word_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the delta list timer queue core.
`timescale 1ns / 100ps

module tb;
	import dltq_pkg::*;

	localparam int NSLOTS     = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASE_REQS = 367;

	// Directed request with an optional hand-written outcome.
	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  id;
		logic [31:0] ticks;
		logic        known;
		logic        e;
		logic [3:0]  eid;
		logic        st;
		logic        qe;
		logic [31:0] pend;
	} probe_row_t;

	localparam probe_row_t PROBE_ROWS [25] = '{
		'{ACT_SVC,  4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b1, 32'd0},
		'{ACT_TICK, 4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b1, 32'd1},
		'{ACT_SVC,  4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b1, 32'd0},
		'{ACT_DEL,  4'd4,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b1, 32'd0},
		'{ACT_ADD,  4'd0,  32'hFFFFFFFF,   1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd0,  32'd5,          1'b1, 1'b0, 4'd0,  1'b1, 1'b0, 32'd0},
		'{ACT_ADD,  4'd15, 32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_SVC,  4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_TICK, 4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 32'd1},
		'{ACT_SVC,  4'd0,  32'd0,          1'b1, 1'b1, 4'd15, 1'b0, 1'b0, 32'd1},
		'{ACT_SVC,  4'd0,  32'd0,          1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd5,  32'd100,        1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd7,  32'd50,         1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd9,  32'hAAAAAAAA,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd10, 32'hFFFFFFFF,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd2,  32'h55555555,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_DEL,  4'd3,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_DEL,  4'd7,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_DEL,  4'd10, 32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_DEL,  4'd9,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_TICK, 4'd0,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_TICK, 4'd15, 32'hFFFFFFFF,   1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_SVC,  4'd0,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_ADD,  4'd12, 32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0},
		'{ACT_SVC,  4'd0,  32'd0,          1'b0, 1'b0, 4'd0,  1'b0, 1'b0, 32'd0}
	};

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Mirror of the timer list.
	logic [31:0] t_delta  [NSLOTS];
	logic [3:0]  t_next   [NSLOTS];
	logic        t_tail   [NSLOTS];
	logic        t_queued [NSLOTS];
	logic [3:0]  t_head;
	logic        t_empty;
	logic [31:0] t_backlog;

	rsp_t queue_outcomes [$];
	int   failures      = 0;
	int   cycle_count   = 0;
	int   send_idle_pct = 7;
	int   rsp_stall_pct = 65;

	delta_list_timer_queue_core #(
		.MAX_TIMERS(NSLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Returns -1 when the slot is the last one in the list.
	function automatic int successor(int s);
		if (t_tail[s])
			return -1;
		return int'(t_next[s]);
	endfunction

	function automatic void link_after(int prev, int s);
		if (prev == -1) begin
			t_head = s[3:0];
		end else begin
			t_next[prev] = s[3:0];
			t_tail[prev] = 1'b0;
		end
	endfunction

	function automatic void insert_timer(int id, logic [31:0] ticks);
		int          prev;
		int          cur;
		int          steps;
		logic [31:0] left;
		prev  = -1;
		cur   = t_empty ? -1 : int'(t_head);
		left  = ticks;
		steps = 0;
		while (cur != -1 && steps < NSLOTS && t_delta[cur] < left) begin
			left  = left - t_delta[cur];
			prev  = cur;
			cur   = successor(cur);
			steps = steps + 1;
		end
		t_delta[id] = left;
		if (cur == -1) begin
			t_tail[id] = 1'b1;
			t_next[id] = '0;
		end else begin
			t_tail[id]   = 1'b0;
			t_next[id]   = cur[3:0];
			t_delta[cur] = t_delta[cur] - left;
		end
		link_after(prev, id);
		t_queued[id] = 1'b1;
		t_empty      = 1'b0;
	endfunction

	// The removed slot's delta is folded into its successor.
	function automatic void detach_slot(int prev, int id);
		int nxt;
		nxt = successor(id);
		if (nxt == -1) begin
			if (prev == -1)
				t_empty = 1'b1;
			else
				t_tail[prev] = 1'b1;
		end else begin
			t_delta[nxt] = t_delta[nxt] + t_delta[id];
			link_after(prev, nxt);
		end
		t_queued[id] = 1'b0;
	endfunction

	function automatic void remove_timer(int id);
		int prev;
		int cur;
		int steps;
		prev  = -1;
		cur   = t_empty ? -1 : int'(t_head);
		steps = 0;
		while (cur != -1 && steps < NSLOTS) begin
			if (cur == id) begin
				detach_slot(prev, id);
				return;
			end
			prev  = cur;
			cur   = successor(cur);
			steps = steps + 1;
		end
	endfunction

	function automatic rsp_t step_timer_queue(req_t r);
		rsp_t res;
		int   h;
		res = '0;
		case (r.action)
			ACT_ADD: begin
				if (t_queued[r.timer_id])
					res.status = 1'b1;
				else
					insert_timer(int'(r.timer_id), r.timeout_ticks);
			end
			ACT_DEL: begin
				if (t_queued[r.timer_id])
					remove_timer(int'(r.timer_id));
			end
			ACT_TICK: begin
				if (t_backlog != 32'hFFFFFFFF)
					t_backlog = t_backlog + 1;
			end
			ACT_SVC: begin
				// An empty list throws the backlog away.
				if (t_empty) begin
					t_backlog = '0;
				end else if (t_backlog != 0) begin
					h = int'(t_head);
					if (t_backlog < t_delta[h]) begin
						t_delta[h] = t_delta[h] - t_backlog;
						t_backlog  = '0;
					end else begin
						t_backlog  = t_backlog - t_delta[h];
						t_delta[h] = '0;
						detach_slot(-1, h);
						res.expired    = 1'b1;
						res.expired_id = h[3:0];
					end
				end
			end
			default: begin
			end
		endcase
		res.queue_empty   = t_empty;
		res.pending_ticks = t_backlog;
		return res;
	endfunction

	function automatic logic [3:0] pick_queued_id();
		logic [3:0] ids [$];
		for (int i = 0; i < NSLOTS; i++)
			if (t_queued[i])
				ids.push_back(i[3:0]);
		if (ids.size() == 0)
			return 4'($urandom_range(15));
		return ids[$urandom_range(ids.size() - 1)];
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// The outcome is worked out once the request has been taken.
	task automatic send_request(req_t r, bit use_lit, rsp_t lit);
		rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = step_timer_queue(r);
		queue_outcomes.push_back(use_lit ? lit : want);
	endtask

	task automatic run_random(int count);
		req_t        r;
		int unsigned pick;
		int unsigned sel;
		repeat (count) begin
			pick            = $urandom_range(99);
			sel             = $urandom_range(9);
			r.timer_id      = 4'($urandom_range(15));
			r.timeout_ticks = $urandom;
			if (pick < 35) begin
				r.action = ACT_ADD;
				// Mostly short timeouts so that timers actually expire.
				if (sel < 7)
					r.timeout_ticks = $urandom_range(12);
				else if (sel == 7)
					r.timeout_ticks = '0;
				else if (sel == 8)
					r.timeout_ticks = '1;
			end else if (pick < 52) begin
				r.action = ACT_DEL;
				if (sel < 8)
					r.timer_id = pick_queued_id();
			end else if (pick < 82) begin
				r.action = ACT_TICK;
			end else begin
				r.action = ACT_SVC;
			end
			send_request(r, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin : outcome_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (queue_outcomes.size() == 0) begin
				$error("response arrived with no request outstanding");
				failures++;
			end else begin
				want = queue_outcomes.pop_front();
				check_field("expired", 32'(want.expired), 32'(rsp.expired));
				check_field("expired_id", 32'(want.expired_id), 32'(rsp.expired_id));
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("queue_empty", 32'(want.queue_empty), 32'(rsp.queue_empty));
				check_field("pending_ticks", want.pending_ticks, rsp.pending_ticks);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		req_t r;
		rsp_t lit;
		for (int i = 0; i < NSLOTS; i++) begin
			t_delta[i]  = '0;
			t_next[i]   = '0;
			t_tail[i]   = 1'b0;
			t_queued[i] = 1'b0;
		end
		t_head    = '0;
		t_empty   = 1'b1;
		t_backlog = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBE_ROWS[i]) begin
			r.action        = PROBE_ROWS[i].action;
			r.timer_id      = PROBE_ROWS[i].id;
			r.timeout_ticks = PROBE_ROWS[i].ticks;
			lit = '{PROBE_ROWS[i].e, PROBE_ROWS[i].eid, PROBE_ROWS[i].st,
				PROBE_ROWS[i].qe, PROBE_ROWS[i].pend};
			send_request(r, PROBE_ROWS[i].known, lit);
		end
		run_random(PHASE_REQS);

		send_idle_pct = 65;
		rsp_stall_pct = 7;
		run_random(PHASE_REQS);

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		run_random(PHASE_REQS);
		req_valid <= 1'b0;

		while (queue_outcomes.size() != 0)
			@(posedge clk);
		repeat (3 * NSLOTS) @(posedge clk);

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
